// ===== src/hte_pkg.sv =====
// Shared types, character constants and tag-word tables for the HTML text extractor.
// No dependencies; every other file but hte_if.sv imports this package.
`default_nettype none

package hte_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Parser mode, one-hot
  typedef enum logic [8:0] {
    MODE_SEEK        = 9'b000000001,  // before body, outside tags
    MODE_SEEK_TAG    = 9'b000000010,  // before body, matching "body"
    MODE_BODY_REST   = 9'b000000100,  // body seen, skip to '>'
    MODE_TEXT        = 9'b000001000,  // in body, outside tags
    MODE_TAG         = 9'b000010000,  // in body, matching "script"
    MODE_SCRIPT_REST = 9'b000100000,  // script seen, skip to '>'
    MODE_BLOCK       = 9'b001000000,  // inside script, outside tags
    MODE_BLOCK_TAG   = 9'b010000000,  // inside script, matching "/script"
    MODE_END_REST    = 9'b100000000   // /script seen, skip to '>'
  } mode_t;

  typedef enum logic [1:0] {
    WORD_BODY,
    WORD_SCRIPT,
    WORD_ENDSCRIPT
  } word_sel_t;

  typedef logic [2:0] match_idx_t;

  typedef struct packed {
    match_idx_t idx;
    logic       done;
  } match_res_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       keep;
    logic       text_end;
  } out_word_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

  function automatic match_idx_t word_len(input word_sel_t sel);
    match_idx_t n;
    unique case (sel)
      WORD_BODY:      n = 3'd4;
      WORD_SCRIPT:    n = 3'd6;
      WORD_ENDSCRIPT: n = 3'd7;
      default:        n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] script_char(input match_idx_t idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h73;  // s
      3'd1:    ch = 8'h63;  // c
      3'd2:    ch = 8'h72;  // r
      3'd3:    ch = 8'h69;  // i
      3'd4:    ch = 8'h70;  // p
      3'd5:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] word_char(input word_sel_t sel, input match_idx_t idx);
    logic [7:0] ch;
    unique case (sel)
      WORD_BODY: begin
        unique case (idx)
          3'd0:    ch = 8'h62;  // b
          3'd1:    ch = 8'h6F;  // o
          3'd2:    ch = 8'h64;  // d
          3'd3:    ch = 8'h79;  // y
          default: ch = 8'h00;
        endcase
      end
      WORD_SCRIPT: ch = script_char(idx);
      WORD_ENDSCRIPT: begin
        if (idx == 3'd0) begin
          ch = 8'h2F;  // '/'
        end else begin
          ch = script_char(idx - 3'd1);
        end
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== src/hte_if.sv =====
// Valid/ready stream interfaces for the HTML text extractor input and result channels.
// Depends on nothing.
`default_nettype none

interface hte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       doc_end;

  modport source (output valid, output data_byte, output doc_end, input ready);
  modport sink   (input valid, input data_byte, input doc_end, output ready);
endinterface

interface hte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       keep;
  logic       text_end;

  modport source (output valid, output text_char, output keep, output text_end, input ready);
  modport sink   (input valid, input text_char, input keep, input text_end, output ready);
endinterface

`default_nettype wire

// ===== src/html_text_extractor.sv =====
// HTML text extractor: flags the visible-text bytes of an HTML byte stream.
// Each result word is registered in the result buffer before it is offered on out_ch.
// Throughput: one byte per cycle; the two-word result buffer keeps input open
// while one result waits, and input stalls only when both buffer slots are full.
// Reset (synchronous, rst_n low): parser back to "seeking body", buffer emptied.
// Depends on hte_pkg, hte_if, hte_word_match and hte_out_fifo.
`default_nettype none

module html_text_extractor
  import hte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  hte_in_if.sink   in_ch,
  hte_out_if.source out_ch
);

  // Parser state: one-hot mode plus letters of the current tag word matched.
  mode_t      mode_r, mode_nxt;
  match_idx_t match_r, match_nxt;

  logic       accept;
  logic       buf_full;
  word_sel_t  word_sel;
  match_res_t mres;
  logic [7:0] c;
  logic       keep;
  out_word_t  res_word;

  assign c        = in_ch.data_byte;
  assign in_ch.ready = !buf_full;
  assign accept   = in_ch.valid && in_ch.ready;

  // Which tag word is being hunted depends on where we are in the document.
  always_comb begin
    unique case (mode_r)
      MODE_TAG:       word_sel = WORD_SCRIPT;
      MODE_BLOCK_TAG: word_sel = WORD_ENDSCRIPT;
      default:        word_sel = WORD_BODY;
    endcase
  end

  hte_word_match u_match (
    .sel    (word_sel),
    .idx_in (match_r),
    .c      (c),
    .res    (mres)
  );

  // Mode transitions; the '>' check wins over matching inside a tag.
  always_comb begin
    mode_nxt  = mode_r;
    match_nxt = match_r;
    keep      = 1'b0;
    unique case (mode_r)
      MODE_SEEK_TAG: begin
        if (c == CH_GT) begin
          mode_nxt = MODE_SEEK;
        end else begin
          match_nxt = mres.idx;
          if (mres.done) mode_nxt = MODE_BODY_REST;
        end
      end
      MODE_BODY_REST: begin
        if (c == CH_GT) mode_nxt = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (c == CH_LT) begin
          mode_nxt  = MODE_TAG;
          match_nxt = '0;
        end else if (c != CH_GT) begin
          keep = 1'b1;  // plain text outside any tag
        end
      end
      MODE_TAG: begin
        if (c == CH_GT) begin
          mode_nxt = MODE_TEXT;
        end else begin
          match_nxt = mres.idx;
          if (mres.done) mode_nxt = MODE_SCRIPT_REST;
        end
      end
      MODE_SCRIPT_REST: begin
        if (c == CH_GT) mode_nxt = MODE_BLOCK;
      end
      MODE_BLOCK: begin
        if (c == CH_LT) begin
          mode_nxt  = MODE_BLOCK_TAG;
          match_nxt = '0;
        end
      end
      MODE_BLOCK_TAG: begin
        if (c == CH_GT) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          match_nxt = mres.idx;
          if (mres.done) mode_nxt = MODE_END_REST;
        end
      end
      MODE_END_REST: begin
        if (c == CH_GT) mode_nxt = MODE_TEXT;
      end
      default: begin
        // seeking body; illegal codes recover here as well
        if (c == CH_LT) begin
          mode_nxt  = MODE_SEEK_TAG;
          match_nxt = '0;
        end else begin
          mode_nxt = MODE_SEEK;
        end
      end
    endcase

    // Last byte of a document: the next byte starts a fresh document.
    if (in_ch.doc_end) begin
      mode_nxt  = MODE_SEEK;
      match_nxt = '0;
    end
  end

  assign res_word.text_char = c;
  assign res_word.keep      = keep;
  assign res_word.text_end  = in_ch.doc_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SEEK;
      match_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
    end
  end

  // Result word buffer toward the output channel.
  hte_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res_word),
    .full      (buf_full),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/hte_word_match.sv =====
// One step of case-insensitive tag-word matching (body, script, /script).
// Depends on hte_pkg.
`default_nettype none

module hte_word_match
  import hte_pkg::*;
(
  input  word_sel_t  sel,
  input  match_idx_t idx_in,
  input  logic [7:0] c,
  output match_res_t res
);

  match_idx_t len;
  match_idx_t idx;
  match_idx_t idx_nxt;

  always_comb begin
    len = word_len(sel);
    idx = (idx_in >= len) ? '0 : idx_in;
    if (word_char(sel, idx) == fold_case(c)) begin
      idx_nxt = idx + 3'd1;
    end else if (c != CH_SPACE) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx;  // spaces are skipped
    end
    res.idx  = idx_nxt;
    res.done = (idx_nxt == len);
  end

endmodule

`default_nettype wire

// ===== src/hte_out_fifo.sv =====
// Two-word result buffer that decouples the parser from the result channel.
// Depends on hte_pkg and hte_out_if.
`default_nettype none

module hte_out_fifo
  import hte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  hte_out_if.source out_ch
);

  out_word_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;
  out_word_t  head;

  assign full = (cnt_r == 2'd2);
  assign pop  = (cnt_r != 2'd0) && out_ch.ready;
  assign head = mem_r[rd_ptr_r];

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.text_char = head.text_char;
  assign out_ch.keep      = head.keep;
  assign out_ch.text_end  = head.text_end;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/hte_checker.sv =====
// Port-level checks for the HTML text extractor, bound to the top level.
// Depends on hte_pkg.
`default_nettype none

module hte_checker
  import hte_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_text_char,
  input logic       out_keep,
  input logic       out_text_end
);

  // A result word stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_text_char) && $stable(out_keep)
                                && $stable(out_text_end))
    else $error("stalled result word changed");

  // Input is held off only when there are results waiting downstream.
  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing buffered");

  // A full buffer stays full until the sink takes a word.
  a_full_persists: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("buffer space appeared without a word leaving");

  // Tag delimiters are never flagged as text.
  a_keep_no_delim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keep |-> out_text_char != CH_LT && out_text_char != CH_GT)
    else $error("tag delimiter flagged as visible text");

endmodule

bind html_text_extractor hte_checker u_hte_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_text_char (out_ch.text_char),
  .out_keep      (out_ch.keep),
  .out_text_end  (out_ch.text_end)
);

`default_nettype wire

// ===== test/html_text_extractor_tb.sv =====
// Self-checking testbench for html_text_extractor: byte streams in, flagged text words out.
// Depends on hte_pkg (modes, word tags, out_word_t), hte_if and the RTL under src/.
`default_nettype none

module html_text_extractor_tb;
  import hte_pkg::*;

  logic clk;
  logic rst_n;

  hte_in_if  in_ch();
  hte_out_if out_ch();

  html_text_extractor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tag words as packed strings, right-aligned: first letter in byte n-1.
  localparam logic [55:0] TXT_BODY      = 56'("body");
  localparam logic [55:0] TXT_SCRIPT    = 56'("script");
  localparam logic [55:0] TXT_ENDSCRIPT = 56'("/script");

  // Parser mirror: mode and match index, same meaning as in the block.
  mode_t      pm;
  match_idx_t mi;

  // Expected result words, oldest first.
  out_word_t text_exp_q[$];

  // Document under construction by the random generator.
  logic [7:0] doc_bytes[$];

  int  n_bytes, n_kept, n_docs, n_checked, n_errors;
  bit  idle_on;

  // ---------------------------------------------------------------------------
  // Text-flag prediction
  // ---------------------------------------------------------------------------

  // One step of tag-word matching. Spaces hold the index, any other miss drops
  // it to zero without retrying the byte against the first letter.
  function automatic bit word_hit(input word_sel_t w, input logic [7:0] c);
    logic [55:0] s;
    logic [7:0]  lc;
    int          n;
    int          k;
    case (w)
      WORD_BODY:   begin s = TXT_BODY;      n = 4; end
      WORD_SCRIPT: begin s = TXT_SCRIPT;    n = 6; end
      default:     begin s = TXT_ENDSCRIPT; n = 7; end
    endcase
    k  = int'(mi);
    if (k >= n) k = 0;
    lc = (c >= "A" && c <= "Z") ? c + CASE_OFS : c;
    if (s[8*(n-1-k) +: 8] == lc) begin
      k++;
    end else if (c != CH_SPACE) begin
      k = 0;
    end
    mi = k[2:0];
    return k == n;
  endfunction

  // Advance the mirror by one byte and say whether the byte is visible text.
  task automatic parse_byte(input logic [7:0] c, input logic last, output logic kp);
    kp = 1'b0;
    case (pm)
      MODE_SEEK_TAG: begin
        if (c == CH_GT) pm = MODE_SEEK;
        else if (word_hit(WORD_BODY, c)) pm = MODE_BODY_REST;
      end
      MODE_BODY_REST: begin
        if (c == CH_GT) pm = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (c == CH_LT) begin
          pm = MODE_TAG;
          mi = '0;
        end else if (c != CH_GT) begin
          kp = 1'b1;
        end
      end
      MODE_TAG: begin
        if (c == CH_GT) pm = MODE_TEXT;
        else if (word_hit(WORD_SCRIPT, c)) pm = MODE_SCRIPT_REST;
      end
      MODE_SCRIPT_REST: begin
        if (c == CH_GT) pm = MODE_BLOCK;
      end
      MODE_BLOCK: begin
        if (c == CH_LT) begin
          pm = MODE_BLOCK_TAG;
          mi = '0;
        end
      end
      MODE_BLOCK_TAG: begin
        if (c == CH_GT) pm = MODE_BLOCK;
        else if (word_hit(WORD_ENDSCRIPT, c)) pm = MODE_END_REST;
      end
      MODE_END_REST: begin
        if (c == CH_GT) pm = MODE_TEXT;
      end
      default: begin
        // seek mode, and any stray code falls back to it
        if (c == CH_LT) begin
          pm = MODE_SEEK_TAG;
          mi = '0;
        end else begin
          pm = MODE_SEEK;
        end
      end
    endcase
    // last byte of a document: next byte starts from scratch
    if (last) begin
      pm = MODE_SEEK;
      mi = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: inputs and outputs both sampled at the rising edge. The input
  // word is recorded first, so even a same-cycle result would find its match.
  // ---------------------------------------------------------------------------

  task automatic flag_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
    n_errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    out_word_t due;
    out_word_t seen;
    logic      kp;
    if (!rst_n) begin
      pm = MODE_SEEK;
      mi = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, in_ch.doc_end, kp);
        due.text_char = in_ch.data_byte;
        due.keep      = kp;
        due.text_end  = in_ch.doc_end;
        text_exp_q.push_back(due);
        n_bytes++;
        if (in_ch.doc_end) n_docs++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.text_char = out_ch.text_char;
        seen.keep      = out_ch.keep;
        seen.text_end  = out_ch.text_end;
        if (text_exp_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, seen);
          n_errors++;
        end else begin
          due = text_exp_q.pop_front();
          if (seen.text_char !== due.text_char)
            flag_field("text_char", due.text_char, seen.text_char);
          if (seen.keep !== due.keep)
            flag_field("keep", {7'd0, due.keep}, {7'd0, seen.keep});
          if (seen.text_end !== due.text_end)
            flag_field("text_end", {7'd0, due.text_end}, {7'd0, seen.text_end});
          if (due.keep) n_kept++;
          n_checked++;
        end
      end
    end
  end

  // Result-side backpressure, changed at the falling edge like every input.
  always @(negedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 22);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one byte, maybe after an idle gap, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.doc_end   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  // Stop sending and let every outstanding result word come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (text_exp_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (text_exp_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, text_exp_q.size());
      n_errors++;
    end
    @(negedge clk);
  endtask

  // Tag word with random case and the odd embedded space.
  task automatic add_word(input string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - CASE_OFS;
      doc_bytes.push_back(c);
      if ($urandom_range(0, 7) == 0) doc_bytes.push_back(CH_SPACE);
    end
  endtask

  // Attribute-ish filler inside a tag; never a bracket.
  task automatic add_attrs();
    logic [7:0] c;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       c = CH_SPACE;
        1:       c = "=";
        2:       c = "\"";
        default: begin
          c = "a";
          c = c + 8'($urandom_range(0, 25));
        end
      endcase
      doc_bytes.push_back(c);
    end
  endtask

  // Text between tags: any byte value except an opening bracket.
  task automatic add_text(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LT) b = CH_SPACE;
      doc_bytes.push_back(b);
    end
  endtask

  task automatic add_tag(input string name);
    doc_bytes.push_back(CH_LT);
    if ($urandom_range(0, 2) == 0) doc_bytes.push_back("/");
    add_word(name);
    add_attrs();
    doc_bytes.push_back(CH_GT);
  endtask

  // Plain tag names, near misses of the tag words among them.
  function automatic string tag_name(input int k);
    case (k)
      0:       return "p";
      1:       return "bod";
      2:       return "scrip";
      3:       return "span";
      4:       return "body";
      5:       return "br";
      default: return "div";
    endcase
  endfunction

  // Script block: opening tag, content with decoy tags, closing tag
  // (occasionally misspelled so the block runs on).
  task automatic add_script();
    doc_bytes.push_back(CH_LT);
    add_word("script");
    add_attrs();
    doc_bytes.push_back(CH_GT);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0, 1: add_text($urandom_range(1, 8));
        2:    add_tag(tag_name($urandom_range(0, 6)));
        default: begin
          doc_bytes.push_back(CH_LT);
          add_word("/scr");
          doc_bytes.push_back(CH_GT);
        end
      endcase
    end
    doc_bytes.push_back(CH_LT);
    if ($urandom_range(0, 9) == 0) add_word("/scirpt");
    else add_word("/script");
    add_attrs();
    doc_bytes.push_back(CH_GT);
  endtask

  // Mostly well-formed document with random content.
  task automatic build_doc();
    doc_bytes.delete();
    if ($urandom_range(0, 1)) add_text($urandom_range(0, 6));
    if ($urandom_range(0, 2) == 0) add_tag("head");
    if ($urandom_range(0, 4) == 0) add_tag("bod");
    doc_bytes.push_back(CH_LT);
    if ($urandom_range(0, 4) == 0) add_attrs();
    if ($urandom_range(0, 9) == 0) add_word("bdoy");   // misspelled body tag: text up to any later body tag is dropped
    else add_word("body");
    add_attrs();
    doc_bytes.push_back(CH_GT);
    repeat ($urandom_range(2, 8)) begin
      case ($urandom_range(0, 3))
        0, 1: add_text($urandom_range(1, 10));
        2:    add_tag(tag_name($urandom_range(0, 6)));
        default: add_script();
      endcase
    end
    // now and then the document stops inside an open tag
    if ($urandom_range(0, 9) == 0) begin
      doc_bytes.push_back(CH_LT);
      add_word("scr");
    end
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++) begin
      send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked cases: mismatch not retried, spaced mixed-case body with the
  // rest of its tag skipped, byte extremes, stray '>', tag open at the end,
  // and a fresh document after the end flag.
  task automatic test_directed();
    send_str("<bbody>x", 1'b1);       // "bb" breaks the match: nothing kept
    send_str("<B oDy q>", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_GT, 1'b0);           // stray close bracket is dropped
    send_byte(CH_LT, 1'b1);           // document ends inside a tag
    send_str("A", 1'b1);              // back in seek mode: dropped
    wait_drained();
  endtask

  // Random documents; one stretch runs with no idling on either side.
  task automatic test_random_docs();
    int start;
    start = n_bytes;
    while (n_bytes - start < 720) begin
      idle_on = !((n_bytes - start) >= 250 && (n_bytes - start) < 420);
      build_doc();
      send_doc();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  // Noise: bracket-heavy random bytes with tag-word fragments and random ends.
  task automatic test_noise();
    int         start;
    logic [7:0] b;
    string      letters;
    letters = "bodyscript/";
    start   = n_bytes;
    while (n_bytes - start < 220) begin
      case ($urandom_range(0, 11))
        0, 1: send_byte(CH_LT, $urandom_range(0, 29) == 0);
        2:    send_byte(CH_GT, $urandom_range(0, 29) == 0);
        3:    send_byte(CH_SPACE, 1'b0);
        4: begin
          b = letters[$urandom_range(0, 10)];
          if (b >= "a" && b <= "z" && $urandom_range(0, 1)) b = b - CASE_OFS;
          send_byte(b, 1'b0);
        end
        5:    send_str("<body>", 1'b0);
        6:    send_str("<script>", 1'b0);
        7:    send_str("</script>", 1'b0);
        default: begin
          b = 8'($urandom_range(0, 255));
          send_byte(b, $urandom_range(0, 29) == 0);
        end
      endcase
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    n_bytes         = 0;
    n_kept          = 0;
    n_docs          = 0;
    n_checked       = 0;
    n_errors        = 0;
    idle_on         = 1'b1;
    pm              = MODE_SEEK;
    mi              = '0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.doc_end   = 1'b0;
    out_ch.ready    = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_docs();
    test_noise();

    // quiet cycles at the end catch any extra result word
    repeat (6) @(posedge clk);

    $display("Covered %0d bytes (%0d ended documents), %0d words checked, %0d kept as text.",
             n_bytes, n_docs, n_checked, n_kept);
    if (n_errors == 0 && text_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
